// ===== rtl/udiv_pkg.sv =====
// ---------------------------------------------------------------------------
// udiv_pkg
// Shared types and constants for the unsigned divider: field widths,
// sequencer states and the control bundle that drives the cell row.
// ---------------------------------------------------------------------------
package udiv_pkg;

    localparam int FIELD_WIDTH        = 64;
    localparam int DATA_WIDTH_DEFAULT = 64;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // control from the sequencer to the cell row and the output stage
    typedef struct packed {
        logic in_ready;
        logic load;
        logic step;
        logic finish;
    } ctrl_t;

endpackage

// ===== rtl/udiv_if.sv =====
// ---------------------------------------------------------------------------
// udiv_req_if / udiv_rsp_if
// Valid/ready channels for divider requests (dividend, divisor) and
// responses (quotient, remainder, divide_by_zero).
// ---------------------------------------------------------------------------
interface udiv_req_if;
    import udiv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] dividend;
    logic [FIELD_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udiv_rsp_if;
    import udiv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] quotient;
    logic [FIELD_WIDTH-1:0] remainder;
    logic                   divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input divide_by_zero, output ready);
endinterface

// ===== rtl/udiv64_quotient_remainder.sv =====
// ---------------------------------------------------------------------------
// udiv64_quotient_remainder
// Unsigned DATA_WIDTH by DATA_WIDTH divider built from a row of bit cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (sink): dividend and divisor; only the low DATA_WIDTH bits
//   are used. rsp channel (source): quotient, remainder and divide_by_zero,
//   zero-extended to 64 bits.
//   One transaction is in flight at a time. After acceptance the cell row
//   runs DATA_WIDTH restoring steps, one quotient bit per cycle. The
//   sequencer then waits until the output register is free and loads the
//   result into it; rsp.valid rises as it is loaded and req.ready returns
//   with it, so a new request is taken only once the previous result has
//   left the cells. A zero divisor yields an all-ones quotient, the
//   dividend as remainder and divide_by_zero set, through the same steps.
//   While the receiver stalls, the result waits in the output register and
//   the next request is still taken; if that one finishes before the
//   register drains, the cells hold it until the register is taken.
//   Reset clears the sequencer and the output valid; no clearing pass.
// ---------------------------------------------------------------------------
module udiv64_quotient_remainder #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    udiv_req_if.sink   req,
    udiv_rsp_if.source rsp
);
    import udiv_pkg::*;

    ctrl_t                  ctrl;
    logic                   out_free;
    logic                   sub;
    logic [DATA_WIDTH-1:0]  r_bits;
    logic [DATA_WIDTH-1:0]  nq_bits;
    logic [DATA_WIDTH-1:0]  borrow;
    logic [DATA_WIDTH-1:0]  n_in;
    logic [DATA_WIDTH-1:0]  d_in;

    logic                   valid_reg, valid_next;
    logic [DATA_WIDTH-1:0]  q_reg;
    logic [DATA_WIDTH-1:0]  rem_reg;
    logic                   dz_reg;
    logic                   dz_work_reg;

    assign n_in     = req.dividend[DATA_WIDTH-1:0];
    assign d_in     = req.divisor[DATA_WIDTH-1:0];
    assign out_free = !valid_reg || rsp.ready;

    udiv_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign req.ready = ctrl.in_ready;

    // subtract when the shifted-out bit was set or no borrow left the top
    assign sub = r_bits[DATA_WIDTH-1] | ~borrow[DATA_WIDTH-1];

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        logic r_src, nq_src, b_src;
        if (i == 0)
        begin : g_low
            assign r_src  = nq_bits[DATA_WIDTH-1];
            assign nq_src = sub;
            assign b_src  = 1'b0;
        end
        else
        begin : g_mid
            assign r_src  = r_bits[i-1];
            assign nq_src = nq_bits[i-1];
            assign b_src  = borrow[i-1];
        end

        udiv_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sub        (sub),
            .n_load     (n_in[i]),
            .d_load     (d_in[i]),
            .r_in       (r_src),
            .nq_in      (nq_src),
            .borrow_in  (b_src),
            .r_out      (r_bits[i]),
            .nq_out     (nq_bits[i]),
            .borrow_out (borrow[i])
        );
    end

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        priority if (ctrl.finish)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dz_work_reg <= (d_in == '0);
        end
        if (ctrl.finish)
        begin
            q_reg   <= nq_bits;
            rem_reg <= r_bits;
            dz_reg  <= dz_work_reg;
        end
    end

    assign rsp.valid          = valid_reg;
    assign rsp.quotient       = FIELD_WIDTH'(q_reg);
    assign rsp.remainder      = FIELD_WIDTH'(rem_reg);
    assign rsp.divide_by_zero = dz_reg;

endmodule

// ===== rtl/udiv_cell.sv =====
// ---------------------------------------------------------------------------
// udiv_cell
// One bit slice of the divider: a remainder bit, a divisor bit and a
// dividend/quotient bit, with its stage of the subtract borrow chain.
// ---------------------------------------------------------------------------
module udiv_cell (
    input  logic            clk,
    input  udiv_pkg::ctrl_t ctrl,
    input  logic            sub,
    input  logic            n_load,
    input  logic            d_load,
    input  logic            r_in,
    input  logic            nq_in,
    input  logic            borrow_in,
    output logic            r_out,
    output logic            nq_out,
    output logic            borrow_out
);
    import udiv_pkg::*;

    logic r_reg, r_next;
    logic d_reg, d_next;
    logic nq_reg, nq_next;
    logic diff;

    // shifted remainder bit minus divisor bit
    assign diff       = r_in ^ d_reg ^ borrow_in;
    assign borrow_out = (~r_in & d_reg) | (~(r_in ^ d_reg) & borrow_in);

    always_comb
    begin
        r_next  = r_reg;
        d_next  = d_reg;
        nq_next = nq_reg;
        priority if (ctrl.load)
        begin
            r_next  = 1'b0;
            d_next  = d_load;
            nq_next = n_load;
        end
        else if (ctrl.step)
        begin
            r_next  = sub ? diff : r_in;
            nq_next = nq_in;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        d_reg  <= d_next;
        nq_reg <= nq_next;
    end

    assign r_out  = r_reg;
    assign nq_out = nq_reg;

endmodule

// ===== rtl/udiv_ctrl.sv =====
// ---------------------------------------------------------------------------
// udiv_ctrl
// Sequencer: takes a transaction, runs one step per cycle over the
// operand width, then hands the result to the output register once it is free.
// ---------------------------------------------------------------------------
module udiv_ctrl #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_free,
    output udiv_pkg::ctrl_t ctrl
);
    import udiv_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        ctrl          = '0;
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // cells hold the result until the output register frees up
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/udiv_chk.sv =====
// ---------------------------------------------------------------------------
// udiv_chk
// Port-level checks for the divider, bound to the top level.
// ---------------------------------------------------------------------------
module udiv_chk #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [udiv_pkg::FIELD_WIDTH-1:0] quotient,
    input  logic                             divide_by_zero
);
    import udiv_pkg::*;

    localparam logic [FIELD_WIDTH-1:0] Q_ALL_ONES = FIELD_WIDTH'({DATA_WIDTH{1'b1}});

    // a waiting result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one transaction in flight: no second accept right after the first
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a new result only appears while a transaction is being worked on
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a transaction");

    // zero divisor gives an all-ones quotient
    a_dz_quot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> quotient == Q_ALL_ONES)
        else $error("bad quotient on divide by zero");

endmodule

bind udiv64_quotient_remainder udiv_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_udiv_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .quotient       (rsp.quotient),
    .divide_by_zero (rsp.divide_by_zero)
);
